// ===== rtl/core/rgba8888_texel_format_packer_assert.svh =====
// ----------------------------------------------------------------------------
// rgba8888_texel_format_packer_assert.svh
// assertion macros for the texel packer
// ----------------------------------------------------------------------------
`ifndef RGBA8888_TEXEL_FORMAT_PACKER_ASSERT_SVH
`define RGBA8888_TEXEL_FORMAT_PACKER_ASSERT_SVH

`ifndef SYNTHESIS

// consequent must hold in the same cycle as the antecedent
`define RTFP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RTFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RTFP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define RTFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/core/rtfp_pkg.sv =====
// ----------------------------------------------------------------------------
// rtfp_pkg
// types, format codes and channel arithmetic for the texel packer
// ----------------------------------------------------------------------------
`default_nettype none

package rtfp_pkg;

    // register port geometry
    localparam int unsigned RTFP_ADDR_W = 3;
    localparam int unsigned RTFP_DATA_W = 32;

    // register index, taken from the word address
    localparam logic REG_TEXEL_FORMAT = 1'b0;

    // texel format codes
    localparam logic [2:0] FMT_RGBA32 = 3'd0;
    localparam logic [2:0] FMT_RGBA16 = 3'd1;
    localparam logic [2:0] FMT_IA16   = 3'd2;
    localparam logic [2:0] FMT_IA8    = 3'd3;
    localparam logic [2:0] FMT_IA4    = 3'd4;
    localparam logic [2:0] FMT_I8     = 3'd5;
    localparam logic [2:0] FMT_I4     = 3'd6;

    // byte counts of a result
    localparam logic [2:0] BYTES_1 = 3'd1;
    localparam logic [2:0] BYTES_2 = 3'd2;
    localparam logic [2:0] BYTES_4 = 3'd4;

    // luma weights and channel maxima
    localparam logic [7:0] W_RED   = 8'd76;
    localparam logic [7:0] W_GREEN = 8'd150;
    localparam logic [7:0] W_BLUE  = 8'd29;
    localparam logic [7:0] MAX_5   = 8'd31;
    localparam logic [7:0] MAX_4   = 8'd15;
    localparam logic [7:0] MAX_3   = 8'd7;
    localparam logic [15:0] ROUND_HALF = 16'd127;

    // source pixel as it arrives
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       is_pad;
        logic       row_end;
    } t_pix;

    // pixel after channel narrowing and luma
    typedef struct packed {
        t_pix       pix;
        logic [4:0] red5;
        logic [4:0] green5;
        logic [4:0] blue5;
        logic       alpha1;
        logic [3:0] alpha4;
        logic [7:0] inten;
    } t_mid;

    // (v*m+127)/255 for 8-bit v and m; the divide by 255 is an add and shift,
    // exact while the quotient stays below 256
    function automatic logic [7:0] narrow(input logic [7:0] v, input logic [7:0] m);
        logic [15:0] prod;
        logic [15:0] acc;
        prod = 16'(v) * 16'(m) + ROUND_HALF;
        acc  = prod + {8'd0, prod[15:8]} + 16'd1;
        return acc[15:8];
    endfunction

    // sum of three separately rounded weighted terms, never above 255
    function automatic logic [7:0] intensity(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
        logic [9:0] sum;
        sum = 10'(narrow(r, W_RED)) + 10'(narrow(g, W_GREEN)) + 10'(narrow(b, W_BLUE));
        return sum[7:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rtfp_if.sv =====
// ----------------------------------------------------------------------------
// rtfp_if
// valid/ready stream interfaces for source pixels and packed texels
// ----------------------------------------------------------------------------
`default_nettype none

// source pixel stream
interface rtfp_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       is_pad;
    logic       row_end;

    modport source (output valid, red, green, blue, alpha, is_pad, row_end,
                    input ready);
    modport sink   (input valid, red, green, blue, alpha, is_pad, row_end,
                    output ready);
endinterface

// packed texel stream
interface rtfp_tex_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_data;
    logic [2:0]  out_bytes;

    modport source (output valid, out_data, out_bytes, input ready);
    modport sink   (input valid, out_data, out_bytes, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rtfp_chan.sv =====
// ----------------------------------------------------------------------------
// rtfp_chan
// channel narrowing to 5, 4 and 1 bits, and weighted intensity
// ----------------------------------------------------------------------------
`default_nettype none

module rtfp_chan
    import rtfp_pkg::*;
(
    input  t_pix i_pix,
    output t_mid o_mid
);

    // per-channel rescaling
    always_comb begin
        o_mid.pix    = i_pix;
        o_mid.red5   = 5'(narrow(i_pix.red,   MAX_5));
        o_mid.green5 = 5'(narrow(i_pix.green, MAX_5));
        o_mid.blue5  = 5'(narrow(i_pix.blue,  MAX_5));
        o_mid.alpha4 = 4'(narrow(i_pix.alpha, MAX_4));
        o_mid.alpha1 = |i_pix.alpha;
        o_mid.inten  = intensity(i_pix.red, i_pix.green, i_pix.blue);
    end

endmodule

`default_nettype wire

// ===== rtl/core/rgba8888_texel_format_packer.sv =====
// ----------------------------------------------------------------------------
// rgba8888_texel_format_packer
// converts RGBA8888 pixels to the selected texel format and packs 4-bit texels
// two to a byte
//
// a result passes the input, channel-math and packed-output registers in turn
// throughput: one pixel per cycle unless the output stalls; the three-register
// pipeline (input, channel math, packed output) advances on a single ready chain
// reset (synchronous, active low): pipeline empty, no half byte held,
// format rgba32
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgba8888_texel_format_packer_assert.svh"

module rgba8888_texel_format_packer
    import rtfp_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // register port
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [RTFP_ADDR_W-1:0] paddr,
    input  wire logic [RTFP_DATA_W-1:0] pwdata,
    output logic      [RTFP_DATA_W-1:0] prdata,
    output logic                        pready,
    // streams
    rtfp_pix_if.sink                    i_pix,
    rtfp_tex_if.source                  o_tex
);

    logic        r_v1;
    logic        r_v2;
    logic        r_vo;
    t_pix        r_s1;
    t_mid        r_s2;
    t_mid        n_s2;
    logic [2:0]  r_fmt;
    logic [3:0]  r_held;
    logic        r_pend;
    logic [3:0]  n_held;
    logic        n_pend;
    logic [31:0] r_out_data;
    logic [2:0]  r_out_bytes;
    logic [31:0] n_out_data;
    logic [2:0]  n_out_bytes;
    logic        out_free;
    logic        adv2;
    logic        fire2;
    logic        has_result;
    logic        four_bit;
    logic        fmt_ok;
    logic [3:0]  nib;
    logic [7:0]  inten4;
    logic [7:0]  inten3;
    logic        reg_sel;
    t_pix        in_pix;

    // register port
    assign pready  = 1'b1;
    assign reg_sel = paddr[RTFP_ADDR_W-1];
    assign prdata  = (reg_sel == REG_TEXEL_FORMAT) ? {{(RTFP_DATA_W-3){1'b0}}, r_fmt}
                                                   : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_RGBA32;
        end else if (psel && penable && pwrite && (reg_sel == REG_TEXEL_FORMAT)) begin
            r_fmt <= pwdata[2:0];
        end
    end

    // ready chain from the output register back to the input
    assign out_free    = !r_vo || o_tex.ready;
    assign adv2        = !r_v2 || out_free;
    assign fire2       = r_v2 && adv2;
    assign i_pix.ready = !r_v1 || adv2;

    always_comb begin
        in_pix.red     = i_pix.red;
        in_pix.green   = i_pix.green;
        in_pix.blue    = i_pix.blue;
        in_pix.alpha   = i_pix.alpha;
        in_pix.is_pad  = i_pix.is_pad;
        in_pix.row_end = i_pix.row_end;
    end

    // channel math between input and middle registers
    rtfp_chan u_chan (
        .i_pix (r_s1),
        .o_mid (n_s2)
    );

    // pipeline valids and payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (i_pix.valid && i_pix.ready) begin
                r_v1 <= 1'b1;
            end else if (adv2) begin
                r_v1 <= 1'b0;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
        if (i_pix.valid && i_pix.ready) begin
            r_s1 <= in_pix;
        end
        if (adv2) begin
            r_s2 <= n_s2;
        end
    end

    // format selection and half-byte pairing
    always_comb begin
        inten4      = narrow(r_s2.inten, MAX_4);
        inten3      = narrow(r_s2.inten, MAX_3);
        n_out_data  = '0;
        n_out_bytes = BYTES_1;
        nib         = '0;
        four_bit    = 1'b0;
        fmt_ok      = 1'b1;
        unique case (r_fmt)
            FMT_RGBA32: begin
                n_out_data  = {r_s2.pix.red, r_s2.pix.green, r_s2.pix.blue, r_s2.pix.alpha};
                n_out_bytes = BYTES_4;
            end
            FMT_RGBA16: begin
                n_out_data  = {16'd0, r_s2.red5, r_s2.green5, r_s2.blue5, r_s2.alpha1};
                n_out_bytes = BYTES_2;
            end
            FMT_IA16: begin
                n_out_data  = {16'd0, r_s2.inten, r_s2.pix.alpha};
                n_out_bytes = BYTES_2;
            end
            FMT_IA8: begin
                n_out_data  = {24'd0, inten4[3:0], r_s2.alpha4};
            end
            FMT_IA4: begin
                nib      = {inten3[2:0], r_s2.alpha1};
                four_bit = 1'b1;
            end
            FMT_I8: begin
                n_out_data  = {24'd0, r_s2.inten};
            end
            FMT_I4: begin
                nib      = inten4[3:0];
                four_bit = 1'b1;
            end
            default: begin
                fmt_ok = 1'b0;
            end
        endcase

        // padding gives an all-zero texel
        if (r_s2.pix.is_pad) begin
            n_out_data = '0;
            nib        = '0;
        end

        n_held     = r_held;
        n_pend     = r_pend;
        has_result = fmt_ok;
        if (four_bit) begin
            if (r_pend) begin
                n_out_data = {24'd0, r_held, nib};
                n_held     = '0;
                n_pend     = 1'b0;
            end else if (r_s2.pix.row_end) begin
                n_out_data = {24'd0, nib, 4'd0};
            end else begin
                n_held     = nib;
                n_pend     = 1'b1;
                has_result = 1'b0;
            end
        end
    end

    // half-byte state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_pend <= 1'b0;
            r_vo   <= 1'b0;
        end else begin
            if (fire2) begin
                r_held <= n_held;
                r_pend <= n_pend;
            end
            if (fire2 && has_result) begin
                r_vo <= 1'b1;
            end else if (o_tex.ready) begin
                r_vo <= 1'b0;
            end
        end
        if (fire2 && has_result) begin
            r_out_data  <= n_out_data;
            r_out_bytes <= n_out_bytes;
        end
    end

    assign o_tex.valid     = r_vo;
    assign o_tex.out_data  = r_out_data;
    assign o_tex.out_bytes = r_out_bytes;

    // checks
    `RTFP_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, i_pix.valid && i_pix.ready, r_v1, "accepted pixel lost at input stage")
    `RTFP_ASSERT_SAME(a_held_clear, i_clk, i_rst_n, !r_pend, r_held == 4'd0, "half byte held without pending flag")
    `RTFP_ASSERT_SAME(a_full_stall, i_clk, i_rst_n, r_vo && !o_tex.ready && r_v2 && r_v1, !i_pix.ready, "input taken while pipeline full and stalled")
    `RTFP_ASSERT_NEXT(a_nibble_byte, i_clk, i_rst_n, fire2 && has_result && four_bit, r_vo && (r_out_bytes == BYTES_1), "four-bit result not one byte")
    `RTFP_ASSERT_SAME(a_bytes_legal, i_clk, i_rst_n, r_vo, (r_out_bytes == BYTES_1) || (r_out_bytes == BYTES_2) || (r_out_bytes == BYTES_4), "illegal byte count")

endmodule

`default_nettype wire
